FILE: rtl/fsta_pkg.sv
// fixed step tick accumulator: shared constants, widths and handshake structs
// used by fsta_div and fixed_step_tick_accumulator_top; no dependencies
`default_nettype none

package fsta_pkg;

	// timestamp and fixed point widths
	localparam int TIME_W    = 48;
	localparam int WIN_W     = 11;
	localparam int FRAC_W    = 24;
	localparam int SYNC_W    = 32;
	localparam int ELAP_W    = 34;
	localparam int D_W       = FRAC_W + 1;
	localparam int TPS_W     = 16;
	localparam int SPEED_W   = 24;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 24;
	localparam int TICK_W    = 4;
	localparam int HI_W      = 18;
	localparam int PQ_W      = ELAP_W - 3;

	// shared multiplier operand widths
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 29;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// serial divider sizing
	localparam int DIV_NUM_W = WIN_W + FRAC_W;
	localparam int DIV_DEN_W = TIME_W - 1;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

	// constants of the behaviour
	localparam logic [WIN_W-1:0]   SYNC_WINDOW_MS = 11'd1000;
	localparam logic [7:0]         MAX_TICKS      = 8'd10;
	localparam logic [21:0]        BLEND_W        = 22'd3355443;
	localparam logic [ELAP_W-1:0]  ELAP_LIMIT     = 34'd16777216000;
	localparam logic [HI_W-1:0]    HI_LIMIT       = 18'd256000;
	localparam logic [SYNC_W-1:0]  SYNC_RESET     = 32'h0100_0000;
	localparam logic [D_W-1:0]     D_ONE          = 25'h100_0000;
	localparam logic [TPS_W-1:0]   TPS_RESET      = 16'd5120;
	localparam logic [SPEED_W-1:0] SPEED_RESET    = 24'd65536;

	// division by 1000 as a shift by 3, then x / 125 = (x * DIV125_MUL) >> DIV125_SH,
	// exact for every x below 2^31
	localparam logic [MUL_B_W-1:0] DIV125_MUL     = 29'd274877907;
	localparam int                 DIV125_SH      = 35;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_FACTOR     = 1'b1;

	// divider request and response
	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] dividend;
		logic [DIV_DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [DIV_NUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/fixed_step_tick_accumulator_top.sv
// fixed_step_tick_accumulator_top: turns timestamp pairs into whole ticks and a fraction
// one item per pass of a small sequencer around a shared multiplier and fsta_div
// when the scaled elapsed time saturates, the divide-by-125 states are skipped; when the
// sync window closes on a valid span, the blend first waits for the 35-step serial divider
// one item at a time: the next is accepted after the result is loaded and the sequencer idles
// reset: arst_n clears all timing state, sync factor to 1.0, registers to 20 tps and speed 1.0
`default_nettype none

module fixed_step_tick_accumulator_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [fsta_pkg::TIME_W-1:0]        sys_time_ms,
	input  logic [fsta_pkg::TIME_W-1:0]        hires_time_ms,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [fsta_pkg::TICK_W-1:0]        tick_count,
	output logic [fsta_pkg::FRAC_W-1:0]        partial_tick,
	input  logic                               cfg_we,
	input  logic [fsta_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fsta_pkg::CFG_DAT_W-1:0]     cfg_data
);
	import fsta_pkg::*;

	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_ADV  = 14'b00000000000010,
		S_RDIV = 14'b00000000000100,
		S_BMUL = 14'b00000000001000,
		S_BUPD = 14'b00000000010000,
		S_ELAP = 14'b00000000100000,
		S_MHI  = 14'b00000001000000,
		S_MLO  = 14'b00000010000000,
		S_PSUM = 14'b00000100000000,
		S_DMUL = 14'b00001000000000,
		S_DQ   = 14'b00010000000000,
		S_SPD  = 14'b00100000000000,
		S_TPS  = 14'b01000000000000,
		S_ACC  = 14'b10000000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [TPS_W-1:0]   tps_q;
	logic [SPEED_W-1:0] speed_q;

	// timing state
	logic [TIME_W-1:0] last_sys_q;
	logic [TIME_W-1:0] win_start_q;
	logic [TIME_W-1:0] last_hires_q;
	logic [WIN_W-1:0]  window_q;
	logic [SYNC_W-1:0] sync_q;
	logic [FRAC_W-1:0] acc_q;

	// working registers of one item
	logic [TIME_W-1:0]  sys_q;
	logic [TIME_W-1:0]  hr_q;
	logic [SYNC_W-1:0]  diff_q;
	logic               up_q;
	logic [ELAP_W-1:0]  e_q;
	logic [HI_W-1:0]    q_q;
	logic               qbig_q;
	logic [PQ_W-1:0]    pq_q;
	logic [D_W-1:0]     d_q;
	logic [MUL_P_W-1:0] prod_q;

	// output register
	logic              out_valid_q;
	logic [TICK_W-1:0] tick_q;
	logic [FRAC_W-1:0] part_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic              accept;
	logic              out_free;

	logic [TIME_W-1:0] adv;
	logic              in_win;
	logic [WIN_W-1:0]  wsum;
	logic              win_close;
	logic [TIME_W-1:0] span;
	logic              span_ok;
	logic              blend_go;

	logic [SYNC_W-1:0] ratio;
	logic              ratio_up;
	logic [SYNC_W:0]   sync_up;
	logic [53:0]       mag_sum;
	logic [29:0]       mag;
	logic [SYNC_W-1:0] sync_next;

	logic [TIME_W-1:0] ediff;
	logic [ELAP_W-1:0] e_next;

	logic [50:0]       p_sum;
	logic              sat_d;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod;

	logic [40:0]       acc_sum;
	logic [31:0]       acc_sat;
	logic [7:0]        whole;
	logic [7:0]        capped;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// system clock advance and window test
	assign adv       = sys_q - last_sys_q;
	assign in_win    = adv <= TIME_W'(SYNC_WINDOW_MS);
	assign wsum      = window_q + adv[WIN_W-1:0];
	assign win_close = wsum > SYNC_WINDOW_MS;
	assign span      = hr_q - win_start_q;
	assign span_ok   = !span[TIME_W-1] && (span != '0);
	assign blend_go  = in_win && win_close && span_ok;

	// ratio saturation and direction of the blend
	assign ratio    = (|div_rsp.quotient[DIV_NUM_W-1:SYNC_W]) ? '1
			: div_rsp.quotient[SYNC_W-1:0];
	assign ratio_up = ratio >= sync_q;

	// blend update, rounding the downward step away from zero
	assign sync_up = {1'b0, sync_q} + (SYNC_W + 1)'(prod_q[53:24]);
	assign mag_sum = prod_q[53:0] + 54'(24'hFF_FFFF);
	assign mag     = mag_sum[53:24];
	always_comb begin
		if (up_q) begin
			sync_next = sync_up[SYNC_W] ? '1 : sync_up[SYNC_W-1:0];
		end else begin
			sync_next = (SYNC_W'(mag) > sync_q) ? '0 : sync_q - SYNC_W'(mag);
		end
	end

	// elapsed high-resolution time, zero when negative, clamped to the limit
	assign ediff = hr_q - last_hires_q;
	always_comb begin
		if (ediff[TIME_W-1]) begin
			e_next = '0;
		end else if (ediff > TIME_W'(ELAP_LIMIT)) begin
			e_next = ELAP_LIMIT;
		end else begin
			e_next = ediff[ELAP_W-1:0];
		end
	end

	// elapsed times sync factor, recombined from the two half products
	assign p_sum = {1'b0, q_q, 16'b0} + {1'b0, prod_q[49:0]};
	assign sat_d = qbig_q || (p_sum >= 51'(ELAP_LIMIT));

	// serial divider: ratio of window length to span for the blend
	always_comb begin
		div_req.start    = (state_q == S_ADV) && blend_go;
		div_req.dividend = {wsum, FRAC_W'(0)};
		div_req.divisor  = span[DIV_DEN_W-1:0];
	end

	fsta_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// shared multiplier operand selection
	always_comb begin
		case (state_q)
			S_BMUL: begin
				mul_a = MUL_A_W'(diff_q);
				mul_b = MUL_B_W'(BLEND_W);
			end
			S_MHI: begin
				mul_a = e_q;
				mul_b = MUL_B_W'(sync_q[31:16]);
			end
			S_MLO: begin
				mul_a = e_q;
				mul_b = MUL_B_W'(sync_q[15:0]);
			end
			S_DMUL: begin
				mul_a = MUL_A_W'(pq_q);
				mul_b = DIV125_MUL;
			end
			S_SPD: begin
				mul_a = MUL_A_W'(d_q);
				mul_b = MUL_B_W'(speed_q);
			end
			S_TPS: begin
				mul_a = MUL_A_W'(prod_q[47:16]);
				mul_b = MUL_B_W'(tps_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

	// accumulator with saturation and tick extraction
	assign acc_sum = 41'(acc_q) + 41'(prod_q[47:8]);
	assign acc_sat = (|acc_sum[40:32]) ? '1 : acc_sum[31:0];
	assign whole   = acc_sat[31:24];
	assign capped  = (whole > MAX_TICKS) ? MAX_TICKS : whole;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q   <= TPS_RESET;
			speed_q <= SPEED_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TICKS_PER_SECOND: tps_q   <= cfg_data[TPS_W-1:0];
				REG_SPEED_FACTOR:     speed_q <= cfg_data[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and timing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			last_sys_q   <= '0;
			win_start_q  <= '0;
			last_hires_q <= '0;
			window_q     <= '0;
			sync_q       <= SYNC_RESET;
			acc_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if ((state_q == S_ACC) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_ADV;
					end
				end
				S_ADV: begin
					last_sys_q <= sys_q;
					if (in_win) begin
						if (win_close) begin
							window_q    <= '0;
							win_start_q <= hr_q;
							state_q     <= span_ok ? S_RDIV : S_ELAP;
						end else begin
							window_q <= wsum;
							state_q  <= S_ELAP;
						end
					end else begin
						last_hires_q <= hr_q;
						state_q      <= S_ELAP;
					end
				end
				S_RDIV: begin
					if (div_rsp.done) begin
						state_q <= S_BMUL;
					end
				end
				S_BMUL: state_q <= S_BUPD;
				S_BUPD: begin
					sync_q  <= sync_next;
					state_q <= S_ELAP;
				end
				S_ELAP: begin
					last_hires_q <= hr_q;
					state_q      <= S_MHI;
				end
				S_MHI:  state_q <= S_MLO;
				S_MLO:  state_q <= S_PSUM;
				S_PSUM: state_q <= sat_d ? S_SPD : S_DMUL;
				S_DMUL: state_q <= S_DQ;
				S_DQ:   state_q <= S_SPD;
				S_SPD:  state_q <= S_TPS;
				S_TPS:  state_q <= S_ACC;
				S_ACC: begin
					if (out_free) begin
						acc_q   <= acc_sat[FRAC_W-1:0];
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers of the item in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			sys_q <= sys_time_ms;
			hr_q  <= hires_time_ms;
		end
		if ((state_q == S_RDIV) && div_rsp.done) begin
			up_q   <= ratio_up;
			diff_q <= ratio_up ? ratio - sync_q : sync_q - ratio;
		end
		if (state_q == S_ELAP) begin
			e_q <= e_next;
		end
		if (state_q == S_MLO) begin
			q_q    <= prod_q[HI_W-1:0];
			qbig_q <= prod_q[49:0] >= 50'(HI_LIMIT);
		end
		// divide by 1000: drop three bits here, then multiply by the reciprocal of 125
		if (state_q == S_PSUM) begin
			if (sat_d) begin
				d_q <= D_ONE;
			end else begin
				pq_q <= p_sum[ELAP_W-1:3];
			end
		end
		if (state_q == S_DQ) begin
			d_q <= {1'b0, prod_q[DIV125_SH+FRAC_W-1:DIV125_SH]};
		end
		if (state_q inside {S_BMUL, S_MHI, S_MLO, S_DMUL, S_SPD, S_TPS}) begin
			prod_q <= prod;
		end
		if ((state_q == S_ACC) && out_free) begin
			tick_q <= capped[TICK_W-1:0];
			part_q <= acc_sat[FRAC_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign tick_count   = tick_q;
	assign partial_tick = part_q;

`ifndef SYNTHESIS
	a_window_bound: assert property (@(posedge clk) disable iff (!arst_n)
		window_q <= SYNC_WINDOW_MS)
		else $error("window counter beyond the sync window");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_RDIV))
		else $error("divider result with no state waiting for it");

	a_elapsed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SPD) |-> (d_q <= D_ONE))
		else $error("scaled elapsed time above one second");

	a_tick_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (tick_q <= TICK_W'(MAX_TICKS)))
		else $error("tick count above the cap");
`endif

endmodule

`default_nettype wire

FILE: rtl/fsta_div.sv
// fsta_div: restoring serial divider, one quotient bit per cycle
// depends on fsta_pkg for widths and the request and response structs
`default_nettype none

module fsta_div (
	input  logic               clk,
	input  logic               arst_n,
	input  fsta_pkg::div_req_t req,
	output fsta_pkg::div_rsp_t rsp
);
	import fsta_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   trial_sub;
	logic                 fits;

	// shift the next dividend bit into the partial remainder and try a subtract
	assign trial     = {rem_q, quo_q[DIV_NUM_W-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign fits      = trial >= {1'b0, den_q};

	// step counter and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DIV_NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// quotient bits replace dividend bits as they are shifted out
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
		end
	end

	assign rsp = '{busy: busy_q, done: done_q, quotient: quo_q};

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// testbench for fixed_step_tick_accumulator_top: directed and random timestamp items,
// each result checked against a tick predictor held in a small scoreboard class
// depends on fsta_pkg and fixed_step_tick_accumulator_top

module testbench;
	import fsta_pkg::*;

	localparam bit [63:0]        TIME_MASK    = 64'h0000_FFFF_FFFF_FFFF;
	localparam bit [TIME_W-1:0]  TIME_MAX     = '1;
	localparam bit [TIME_W-1:0]  TIME_HALF    = 48'h7FFF_FFFF_FFFF;
	localparam int               CYCLE_LIMIT  = 500000;
	localparam int               DRAIN_CYCLES = 100;

	typedef struct packed {
		logic [TICK_W-1:0] ticks;
		logic [FRAC_W-1:0] frac;
	} tick_result_t;

	// scoreboard: own copy of the timing state, the registers and the expected ticks
	class tick_ledger;
		bit [63:0] rate, speed;
		bit [63:0] prev_sys, window_origin, window_acc, prev_hires, sync, acc;
		tick_result_t expected_ticks[$];
		int mismatches;

		function new();
			rate          = TPS_RESET;
			speed         = SPEED_RESET;
			prev_sys      = 0;
			window_origin = 0;
			window_acc    = 0;
			prev_hires    = 0;
			sync          = SYNC_RESET;
			acc           = 0;
			mismatches    = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] value);
			if (index == REG_TICKS_PER_SECOND) begin
				rate = value[TPS_W-1:0];
			end else begin
				speed = value;
			end
		endfunction

		// forward difference modulo the timestamp width, zero when backwards
		function bit [63:0] forward_span(bit [63:0] a, bit [63:0] b);
			bit [63:0] d;
			d = (a - b) & TIME_MASK;
			return d[TIME_W-1] ? 64'd0 : d;
		endfunction

		// blend window / span into the sync factor with weight 0.2
		function void blend_window(bit [63:0] span);
			bit [63:0] ratio, prod, mag;
			ratio = (window_acc << 24) / span;
			if (ratio > 64'hFFFF_FFFF)
				ratio = 64'hFFFF_FFFF;
			if (ratio >= sync) begin
				prod = (ratio - sync) * BLEND_W;
				sync = sync + (prod >> 24);
			end else begin
				prod = (sync - ratio) * BLEND_W;
				mag  = (prod + 64'h00FF_FFFF) >> 24;
				sync = (mag > sync) ? 64'd0 : sync - mag;
			end
			if (sync > 64'hFFFF_FFFF)
				sync = 64'hFFFF_FFFF;
		endfunction

		// elapsed ms times sync factor, in seconds as Q1.24, limited to one second
		function bit [63:0] scaled_elapsed_q24(bit [63:0] e);
			bit [63:0] hi, lo, q, p;
			hi = sync >> 16;
			lo = sync & 64'hFFFF;
			if (e > ELAP_LIMIT)
				e = ELAP_LIMIT;
			q = e * hi;
			if (q >= HI_LIMIT)
				return D_ONE;
			p = (q << 16) + e * lo;
			if (p >= ELAP_LIMIT)
				return D_ONE;
			return p / 64'd1000;
		endfunction

		// one accepted item: update the state and queue the ticks it yields
		function void note_timestamps(bit [TIME_W-1:0] sys_in, bit [TIME_W-1:0] hr_in);
			bit [63:0] s, h, adv, span, d, inc, ticks;
			tick_result_t r;
			s   = sys_in;
			h   = hr_in;
			adv = (s - prev_sys) & TIME_MASK;
			if (adv <= SYNC_WINDOW_MS) begin
				window_acc = window_acc + adv;
				if (window_acc > SYNC_WINDOW_MS) begin
					span = forward_span(h, window_origin);
					if (span != 0)
						blend_window(span);
					window_origin = h;
					window_acc    = 0;
				end
			end else begin
				prev_hires = h;
			end
			prev_sys = s;

			d          = scaled_elapsed_q24(forward_span(h, prev_hires));
			prev_hires = h;

			inc = (((d * speed) >> 16) * rate) >> 8;
			acc = acc + inc;
			if (acc > 64'hFFFF_FFFF)
				acc = 64'hFFFF_FFFF;
			ticks = acc >> 24;
			acc   = acc & 64'h00FF_FFFF;
			if (ticks > MAX_TICKS)
				ticks = MAX_TICKS;

			r.ticks = ticks[TICK_W-1:0];
			r.frac  = acc[FRAC_W-1:0];
			expected_ticks.push_back(r);
		endfunction

		task report_mismatch(string what, bit [63:0] got, bit [63:0] wanted);
			$display("testbench: %s mismatch: got %0d, expected %0d", what, got, wanted);
			mismatches++;
		endtask

		task check_ticks(logic [TICK_W-1:0] ticks, logic [FRAC_W-1:0] frac);
			tick_result_t want;
			if (expected_ticks.size() == 0) begin
				report_mismatch("unexpected result item, tick_count", ticks, 0);
				return;
			end
			want = expected_ticks.pop_front();
			if (ticks !== want.ticks)
				report_mismatch("tick_count", ticks, want.ticks);
			if (frac !== want.frac)
				report_mismatch("partial_tick", frac, want.frac);
		endtask

		function int pending();
			return expected_ticks.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [TIME_W-1:0]    sys_time_ms;
	logic [TIME_W-1:0]    hires_time_ms;
	logic                 out_valid;
	logic                 out_ready;
	logic [TICK_W-1:0]    tick_count;
	logic [FRAC_W-1:0]    partial_tick;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	tick_ledger        ledger;
	int                send_idle_pct = 38;
	int                recv_idle_pct = 83;
	int                hold_left     = 0;
	int                cycle_count   = 0;
	bit [TIME_W-1:0]   cur_sys       = '0;
	bit [TIME_W-1:0]   cur_hr        = '0;

	fixed_step_tick_accumulator_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sys_time_ms   (sys_time_ms),
		.hires_time_ms (hires_time_ms),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.tick_count    (tick_count),
		.partial_tick  (partial_tick),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver: random stalls, or a long counted hold-off when asked
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			ledger.check_ticks(tick_count, partial_tick);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	function automatic bit [TIME_W-1:0] random_time();
		bit [63:0] r;
		r = {$urandom, $urandom};
		return r[TIME_W-1:0];
	endfunction

	// offer one item, with random idle cycles first; returns at the accepting edge
	task automatic offer_item(input bit [TIME_W-1:0] s, input bit [TIME_W-1:0] h);
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		sys_time_ms   <= s;
		hires_time_ms <= h;
		do
			@(posedge clk);
		while (!in_ready);
		ledger.note_timestamps(s, h);
	endtask

	// stop offering and wait for every outstanding result
	task automatic settle_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (ledger.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// both registers; spare upper data bits on the rate write are random
	task automatic write_regs(input logic [TPS_W-1:0] tps, input logic [SPEED_W-1:0] spd);
		logic [CFG_DAT_W-1:0] rate_word;
		rate_word = {(CFG_DAT_W-TPS_W)'($urandom), tps};
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TICKS_PER_SECOND;
		cfg_data  <= rate_word;
		@(negedge clk);
		cfg_index <= REG_SPEED_FACTOR;
		cfg_data  <= spd;
		@(negedge clk);
		cfg_we    <= 1'b0;
		ledger.set_register(REG_TICKS_PER_SECOND, rate_word);
		ledger.set_register(REG_SPEED_FACTOR, spd);
	endtask

	// mostly steady clocks with jitter, plus jumps, backward steps and wild values
	task automatic run_random_items(input int count, input int pause_at);
		bit [TIME_W-1:0] adv;
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				adv     = ($urandom_range(0, 9) == 0) ? TIME_W'($urandom_range(0, 1000))
				                                      : TIME_W'($urandom_range(0, 40));
				cur_sys = cur_sys + adv;
				cur_hr  = cur_hr + adv + TIME_W'($urandom_range(0, 8));
				cur_hr  = cur_hr - 4;
			end else if (pick < 80) begin
				if ($urandom_range(0, 1))
					cur_sys = cur_sys - TIME_W'($urandom_range(1, 5000));
				else
					cur_sys = cur_sys + TIME_W'($urandom_range(1001, 200000));
				cur_hr = cur_hr + TIME_W'($urandom_range(0, 300));
			end else if (pick < 88) begin
				cur_sys = cur_sys + TIME_W'($urandom_range(0, 30));
				if ($urandom_range(0, 1))
					cur_hr = cur_hr + TIME_W'($urandom_range(0, 5000));
				else
					cur_hr = cur_hr - TIME_W'($urandom_range(1, 500));
			end else if (pick < 94) begin
				cur_sys = random_time();
				cur_hr  = random_time();
			end else begin
				cur_sys = TIME_MAX - TIME_W'($urandom_range(0, 600));
				cur_hr  = TIME_MAX - TIME_W'($urandom_range(0, 600));
			end
			offer_item(cur_sys, cur_hr);
			if (n == pause_at)
				settle_results();
		end
	endtask

	task automatic run_phase(input logic [TPS_W-1:0] tps, input logic [SPEED_W-1:0] spd,
	                         input int send_pct, input int recv_pct, input int count,
	                         input int pause_at, input int hold);
		settle_results();
		write_regs(tps, spd);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		hold_left     = hold;
		run_random_items(count, pause_at);
	endtask

	initial begin
		ledger        = new();
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		sys_time_ms   = '0;
		hires_time_ms = '0;
		cfg_we        = 1'b0;
		cfg_index     = REG_TICKS_PER_SECOND;
		cfg_data      = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// steady start, then a window that closes with a span slightly over its length
		offer_item(0, 0);
		offer_item(10, 10);
		offer_item(1010, 1012);
		offer_item(1011, 1013);
		// backward system step, then one too large: both resync
		offer_item(500, 1100);
		offer_item(1502, 1300);
		// high-resolution clock steps back
		offer_item(1510, 1250);
		// window closes with zero span, then with a negative span
		offer_item(2500, 1012);
		offer_item(2502, 1012);
		offer_item(3502, 1500);
		offer_item(3503, 1000);
		// one ms span: ratio saturates, sync factor jumps, elapsed time saturates
		offer_item(4503, 1000);
		offer_item(4504, 1001);
		offer_item(4510, 1030);
		offer_item(4520, 1100);
		// both clocks wrap
		offer_item(TIME_MAX - 3, TIME_MAX - 5);
		offer_item(2, 4);
		offer_item(TIME_MAX, TIME_MAX);
		offer_item(0, 0);
		// huge forward high-resolution jump
		offer_item(5, TIME_HALF);

		// zero tick rate, then zero speed
		settle_results();
		write_regs('0, SPEED_RESET);
		offer_item(15, TIME_HALF + 300);
		offer_item(25, TIME_HALF + 600);
		settle_results();
		write_regs('1, '0);
		offer_item(35, TIME_HALF + 900);
		offer_item(45, TIME_HALF + 1200);

		// random phases across register settings and idling patterns
		run_phase(TPS_RESET, SPEED_RESET, 38, 83, 100, -1, 0);
		run_phase('1, '1, 38, 83, 100, -1, 0);
		run_phase(16'd1, 24'd1, 83, 38, 100, 50, 0);
		run_phase(TPS_W'($urandom_range(1, 16'hFFFF)), SPEED_W'($urandom_range(0, 24'h03_FFFF)),
		          83, 38, 100, -1, 0);
		run_phase(TPS_W'($urandom_range(0, 16'hFFFF)), SPEED_W'($urandom_range(0, 24'hFF_FFFF)),
		          0, 0, 100, -1, 400);
		run_phase(TPS_RESET, SPEED_RESET, 0, 0, 100, -1, 0);

		// drain and finish
		settle_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (ledger.pending() != 0)
			ledger.report_mismatch("results never delivered, count", ledger.pending(), 0);
		if (ledger.mismatches == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

FILE: fixed_step_tick_accumulator_top.f
rtl/fsta_pkg.sv
rtl/fsta_div.sv
rtl/fixed_step_tick_accumulator_top.sv
verif/testbench.sv
